### design/lpr_pkg.sv
// Package for the line pair relation block: shared widths, relation codes
// and the classification record that travels from the front to the back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    // Fixed widths of the stream fields.
    localparam int FIELD_W     = 16;
    localparam int IN_FIELDS   = 6;
    localparam int OUT_W       = 48;
    localparam int TDATA_IN_W  = 96;
    localparam int TDATA_OUT_W = 104;

    // Defaults for the top-level parameters.
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Entries of the queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 4;

    // Clamp limits of a 48-bit signed coordinate, as magnitudes.
    localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REL_UNIQUE     = 2'd0,
        REL_PARALLEL   = 2'd1,
        REL_COINCIDENT = 2'd2,
        REL_INVALID    = 2'd3
    } relation_t;

    // Classification of one line pair, decided in the front.
    typedef struct packed {
        relation_t relation;
        logic      perp;
        logic      neg_x;
        logic      neg_y;
    } lpr_cls_t;

    localparam int CLS_W = $bits(lpr_cls_t);

endpackage

`default_nettype wire

### design/line_pair_relation.sv
// Line pair relation block: classifies two lines a*x+b*y+c=0 and gives
// their intersection in fixed point. Uses lpr_pkg, lpr_front, lpr_queue
// and lpr_back.
//
// Channels: the slave stream (s_tvalid/s_tready/s_tdata) carries one line
// pair per request; the master stream (m_tvalid/m_tready/m_tdata) returns
// exactly one result per request, in order. A request is taken on a clock
// edge with tvalid and tready both high.
// Throughput: one line pair per cycle, sustained, while the receiver takes
// results. On its way a line pair passes the three front stages, the
// queue and the divider, which spends one stage per quotient bit.
// Stalls: when m_tready is low the back holds; the front keeps accepting
// until the four-entry queue is full and its own last stage holds a
// pair, then drops s_tready.
// Reset: rst_n clears all valid flags and queue pointers; no request is in
// flight afterwards and no initialization pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module line_pair_relation
    import lpr_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // first_a, first_b, first_c, second_a, second_b, second_c (16 bits each)
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,
    // relation[1:0], perpendicular, cross_x[47:0], cross_y[47:0],
    // saturated, then four zero bits
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata
);

    localparam int MW = 2 * COEF_WIDTH;
    localparam int QW = CLS_W + 3 * MW;

    logic             f_valid, f_ready;
    lpr_cls_t         f_cls;
    logic [MW-1:0]    f_mag_x, f_mag_y, f_mag_d;
    logic [QW-1:0]    q_in, q_out;
    logic             b_valid, b_ready;
    lpr_cls_t         b_cls;
    logic [MW-1:0]    b_mag_x, b_mag_y, b_mag_d;
    relation_t        relation;
    logic             perpendicular, saturated;
    logic [OUT_W-1:0] cross_x, cross_y;

    lpr_front #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cls   (f_cls),
        .push_mag_x (f_mag_x),
        .push_mag_y (f_mag_y),
        .push_mag_d (f_mag_d)
    );

    assign q_in = {f_cls, f_mag_x, f_mag_y, f_mag_d};

    lpr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign {b_cls, b_mag_x, b_mag_y, b_mag_d} = q_out;

    lpr_back #(
        .MAG_W     (MW),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (b_valid),
        .pop_ready     (b_ready),
        .pop_cls       (b_cls),
        .pop_mag_x     (b_mag_x),
        .pop_mag_y     (b_mag_y),
        .pop_mag_d     (b_mag_d),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .relation      (relation),
        .perpendicular (perpendicular),
        .cross_x       (cross_x),
        .cross_y       (cross_y),
        .saturated     (saturated)
    );

    // Result packing, first field in the lowest bits.
    assign m_tdata = {4'b0000, saturated, cross_y, cross_x, perpendicular, relation};

    // An invalid line never reports a perpendicular pair.
    a_perp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && relation == REL_INVALID |-> !perpendicular)
        else $error("perpendicular flagged on an invalid line pair");

    // Without a unique point the coordinates and clamp flag are zero.
    a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && relation != REL_UNIQUE |->
            cross_x == '0 && cross_y == '0 && !saturated)
        else $error("coordinates given without a unique intersection");

    // A clamped result has at least one coordinate at one of the two limits.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && saturated |->
            cross_x == POS_LIMIT || cross_x == NEG_LIMIT ||
            cross_y == POS_LIMIT || cross_y == NEG_LIMIT)
        else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

### design/lpr_front.sv
// Front part: takes a line pair, forms the cross products, classifies the
// pair and hands magnitudes and signs to the queue. Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_front
    import lpr_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [TDATA_IN_W-1:0]     in_data,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output lpr_cls_t                       push_cls,
    output logic [2*COEF_WIDTH-1:0]        push_mag_x,
    output logic [2*COEF_WIDTH-1:0]        push_mag_y,
    output logic [2*COEF_WIDTH-1:0]        push_mag_d
);

    localparam int CW = COEF_WIDTH;
    localparam int PW = 2 * CW;

    logic [31:0]          ext [IN_FIELDS];
    logic signed [CW-1:0] coef [IN_FIELDS];
    logic                 adv;

    logic                 f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic                 f1_inv_reg, f2_inv_reg;
    logic signed [PW-1:0] p_a1b2_reg, p_a2b1_reg, p_a1a2_reg;
    logic signed [PW-1:0] p_b1b2_reg, p_b1c2_reg, p_b2c1_reg;
    logic signed [PW-1:0] p_a2c1_reg, p_a1c2_reg;
    logic signed [PW:0]   det_reg, dot_reg, cx_reg, cy_reg;
    lpr_cls_t             cls_reg;
    logic [PW-1:0]        mag_x_reg, mag_y_reg, mag_d_reg;
    lpr_cls_t             cls_next;

    function automatic logic [PW-1:0] magnitude(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = v[PW] ? -v : v;
        return t[PW-1:0];
    endfunction

    // Coefficients: low COEF_WIDTH bits of the zero-extended field, signed.
    always_comb
    begin
        for (int i = 0; i < IN_FIELDS; i++)
        begin
            ext[i]  = 32'(in_data[i*FIELD_W +: FIELD_W]);
            coef[i] = signed'(ext[i][CW-1:0]);
        end
    end

    // The whole front moves when its last stage is empty or is taken.
    assign adv      = !f3_valid_reg || push_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // Stage one: products and the invalid-line test.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_a1b2_reg <= PW'(coef[0]) * PW'(coef[4]);
            p_a2b1_reg <= PW'(coef[3]) * PW'(coef[1]);
            p_a1a2_reg <= PW'(coef[0]) * PW'(coef[3]);
            p_b1b2_reg <= PW'(coef[1]) * PW'(coef[4]);
            p_b1c2_reg <= PW'(coef[1]) * PW'(coef[5]);
            p_b2c1_reg <= PW'(coef[4]) * PW'(coef[2]);
            p_a2c1_reg <= PW'(coef[3]) * PW'(coef[2]);
            p_a1c2_reg <= PW'(coef[0]) * PW'(coef[5]);
            f1_inv_reg <= (coef[0] == '0 && coef[1] == '0) ||
                          (coef[3] == '0 && coef[4] == '0);
        end
    end

    // Stage two: determinant, dot product and the Cramer numerators.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg    <= (PW+1)'(p_a1b2_reg) - (PW+1)'(p_a2b1_reg);
            dot_reg    <= (PW+1)'(p_a1a2_reg) + (PW+1)'(p_b1b2_reg);
            cx_reg     <= (PW+1)'(p_b1c2_reg) - (PW+1)'(p_b2c1_reg);
            cy_reg     <= (PW+1)'(p_a2c1_reg) - (PW+1)'(p_a1c2_reg);
            f2_inv_reg <= f1_inv_reg;
        end
    end

    // Classification. Coincidence needs both numerators zero as well.
    always_comb
    begin
        cls_next.perp  = !f2_inv_reg && (dot_reg == '0);
        cls_next.neg_x = cx_reg[PW] ^ det_reg[PW];
        cls_next.neg_y = cy_reg[PW] ^ det_reg[PW];
        if (f2_inv_reg)
        begin
            cls_next.relation = REL_INVALID;
        end
        else if (det_reg != '0)
        begin
            cls_next.relation = REL_UNIQUE;
        end
        else if (cx_reg == '0 && cy_reg == '0)
        begin
            cls_next.relation = REL_COINCIDENT;
        end
        else
        begin
            cls_next.relation = REL_PARALLEL;
        end
    end

    // Stage three: record and magnitudes for the divider.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg   <= cls_next;
            mag_x_reg <= magnitude(cx_reg);
            mag_y_reg <= magnitude(cy_reg);
            mag_d_reg <= magnitude(det_reg);
        end
    end

    assign push_valid = f3_valid_reg;
    assign push_cls   = cls_reg;
    assign push_mag_x = mag_x_reg;
    assign push_mag_y = mag_y_reg;
    assign push_mag_d = mag_d_reg;

endmodule

`default_nettype wire

### design/lpr_queue.sv
// Short queue between the front and the back of the line pair block.
// Generic register queue; depends on lpr_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module lpr_queue
    import lpr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Storage of queued requests.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/lpr_back.sv
// Back part: pipelined restoring divider, one quotient bit per stage for
// both coordinates, then sign, clamp and the output register. Uses lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_back
    import lpr_pkg::*;
#(
    parameter int MAG_W     = 2 * COEF_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire lpr_cls_t         pop_cls,
    input  wire logic [MAG_W-1:0] pop_mag_x,
    input  wire logic [MAG_W-1:0] pop_mag_y,
    input  wire logic [MAG_W-1:0] pop_mag_d,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output relation_t             relation,
    output logic                  perpendicular,
    output logic [OUT_W-1:0]      cross_x,
    output logic [OUT_W-1:0]      cross_y,
    output logic                  saturated
);

    localparam int MW = MAG_W;
    localparam int NW = MAG_W + FRAC_BITS;
    localparam int EW = NW + OUT_W;

    logic             adv;
    logic             v_reg   [NW+1];
    lpr_cls_t         cls_reg [NW+1];
    logic [MW-1:0]    den_reg [NW+1];
    logic [MW-1:0]    rx_reg  [NW+1];
    logic [MW-1:0]    ry_reg  [NW+1];
    logic [NW-1:0]    qx_reg  [NW+1];
    logic [NW-1:0]    qy_reg  [NW+1];

    logic             out_valid_reg;
    relation_t        relation_reg;
    logic             perp_reg, sat_reg;
    logic [OUT_W-1:0] x_reg, y_reg;
    logic [OUT_W:0]   clamp_x, clamp_y;

    // One restoring step: returns the new remainder above the shifted
    // dividend/quotient word.
    function automatic logic [MW+NW-1:0] div_step(input logic [MW-1:0] rem,
                                                  input logic [NW-1:0] dq,
                                                  input logic [MW-1:0] den);
        logic [MW:0]   trial;
        logic [MW:0]   diff;
        logic          ge;
        logic [MW-1:0] rem_n;
        logic [NW-1:0] dq_n;
        trial = {rem, dq[NW-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
        rem_n = ge ? diff[MW-1:0] : trial[MW-1:0];
        dq_n  = {dq[NW-2:0], ge};
        return {rem_n, dq_n};
    endfunction

    // Sign and clamp: bit OUT_W is the clamp flag, below it the result.
    function automatic logic [OUT_W:0] clamp(input logic [NW-1:0] q,
                                             input logic neg);
        logic [EW-1:0]    qe;
        logic             sat;
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] mag;
        qe  = EW'(q);
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        sat = (qe > EW'(lim));
        mag = sat ? lim : qe[OUT_W-1:0];
        return {sat, (neg ? (OUT_W'(0) - mag) : mag)};
    endfunction

    // The back moves as one when its output is free or is taken.
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pop_valid;
            for (int k = 1; k <= NW; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            out_valid_reg <= v_reg[NW];
        end
    end

    // Divider entry: dividend is the magnitude scaled by the fraction bits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0] <= pop_cls;
            den_reg[0] <= pop_mag_d;
            rx_reg[0]  <= '0;
            ry_reg[0]  <= '0;
            qx_reg[0]  <= NW'(pop_mag_x) << FRAC_BITS;
            qy_reg[0]  <= NW'(pop_mag_y) << FRAC_BITS;
        end
    end

    // Divider stages, one quotient bit each.
    for (genvar k = 1; k <= NW; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cls_reg[k] <= cls_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                {rx_reg[k], qx_reg[k]} <= div_step(rx_reg[k-1], qx_reg[k-1],
                                                   den_reg[k-1]);
                {ry_reg[k], qy_reg[k]} <= div_step(ry_reg[k-1], qy_reg[k-1],
                                                   den_reg[k-1]);
            end
        end
    end

    assign clamp_x = clamp(qx_reg[NW], cls_reg[NW].neg_x);
    assign clamp_y = clamp(qy_reg[NW], cls_reg[NW].neg_y);

    // Output register; coordinates only for a unique intersection.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            relation_reg <= cls_reg[NW].relation;
            perp_reg     <= cls_reg[NW].perp;
            if (cls_reg[NW].relation == REL_UNIQUE)
            begin
                x_reg   <= clamp_x[OUT_W-1:0];
                y_reg   <= clamp_y[OUT_W-1:0];
                sat_reg <= clamp_x[OUT_W] | clamp_y[OUT_W];
            end
            else
            begin
                x_reg   <= '0;
                y_reg   <= '0;
                sat_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign relation      = relation_reg;
    assign perpendicular = perp_reg;
    assign cross_x       = x_reg;
    assign cross_y       = y_reg;
    assign saturated     = sat_reg;

endmodule

`default_nettype wire
